### src/gvcf_pkg.sv
// gvcf_pkg: shared types, widths, register codes and the sequencer microprogram
// for the gravity vector complementary filter. No dependencies.

package gvcf_pkg;

  localparam int VEC_FRAC_BITS_DEF = 29;

  // shared multiplier operand, product and accumulator widths
  localparam int OPW    = 33;
  localparam int PROD_W = 2 * OPW;
  localparam int ACC_W  = 68;
  // accel x gravity before the gain, and its low split
  localparam int D_W    = 49;
  localparam int DL_W   = 24;

  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd42;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE = 2'd1;

  localparam logic [15:0] KP_RESET    = 16'd2097;
  localparam logic [23:0] GS_RESET    = 24'd5856353;
  localparam logic [30:0] GS100_RESET = 31'(32'(GS_RESET) * 32'd100);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] grav_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } out_t;

  typedef enum logic [3:0] {
    A_ZERO, A_C, A_CORR, A_W, A_G, A_T, A_A, A_DH, A_DL, A_TH
  } asel_t;

  typedef enum logic [3:0] {
    B_ZERO, B_GS100, B_GS, B_P40, B_PF, B_G, B_T, B_H, B_K
  } bsel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_SET, ACC_SETNEG, ACC_ADD, ACC_SUB
  } accop_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_RATE, WB_W, WB_T, WB_H, WB_G, WB_D, WB_CORR
  } wb_t;

  typedef struct packed {
    asel_t      a_sel;
    logic [1:0] a_idx;
    bsel_t      b_sel;
    logic [1:0] b_idx;
    accop_t     acc_op;
    logic       acc_shl;
    wb_t        wb;
    logic [1:0] wb_idx;
  } uop_t;

  typedef struct packed {
    logic busy;
    logic done;
    uop_t uop;
  } ctl_t;

  localparam uop_t UOP_IDLE = '{a_sel: A_ZERO, a_idx: 2'd0, b_sel: B_ZERO, b_idx: 2'd0,
                                acc_op: ACC_HOLD, acc_shl: 1'b0, wb: WB_NONE,
                                wb_idx: 2'd0};

  function automatic uop_t uop_mk(input asel_t a, input logic [1:0] ai, input bsel_t b,
                                  input logic [1:0] bi, input accop_t op, input logic shl,
                                  input wb_t wb, input logic [1:0] wi);
    uop_t u;
    u.a_sel   = a;
    u.a_idx   = ai;
    u.b_sel   = b;
    u.b_idx   = bi;
    u.acc_op  = op;
    u.acc_shl = shl;
    u.wb      = wb;
    u.wb_idx  = wi;
    return u;
  endfunction

  // each step: multiply issued now, accumulate of the previous product,
  // writeback of the accumulator as it stood at the start of the step
  function automatic uop_t gvcf_uop(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      // rates: -(c * gs * 100)
      6'd0:  u = uop_mk(A_C,    2'd0, B_GS100, 2'd0, ACC_HOLD,   1'b0, WB_NONE, 2'd0);
      6'd1:  u = uop_mk(A_C,    2'd1, B_GS100, 2'd0, ACC_SETNEG, 1'b0, WB_NONE, 2'd0);
      6'd2:  u = uop_mk(A_C,    2'd2, B_GS100, 2'd0, ACC_SETNEG, 1'b0, WB_RATE, 2'd0);
      // angles: -(c * gs) + corr << (40 - f)
      6'd3:  u = uop_mk(A_C,    2'd0, B_GS,    2'd0, ACC_SETNEG, 1'b0, WB_RATE, 2'd1);
      6'd4:  u = uop_mk(A_CORR, 2'd0, B_P40,   2'd0, ACC_SETNEG, 1'b0, WB_RATE, 2'd2);
      6'd5:  u = uop_mk(A_C,    2'd1, B_GS,    2'd0, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd6:  u = uop_mk(A_CORR, 2'd1, B_P40,   2'd0, ACC_SETNEG, 1'b0, WB_W,    2'd0);
      6'd7:  u = uop_mk(A_C,    2'd2, B_GS,    2'd0, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd8:  u = uop_mk(A_CORR, 2'd2, B_P40,   2'd0, ACC_SETNEG, 1'b0, WB_W,    2'd1);
      // rotation: g << f + w x g
      6'd9:  u = uop_mk(A_W,    2'd1, B_G,     2'd2, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd10: u = uop_mk(A_G,    2'd0, B_PF,    2'd0, ACC_SET,    1'b0, WB_W,    2'd2);
      6'd11: u = uop_mk(A_W,    2'd2, B_G,     2'd1, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd12: u = uop_mk(A_W,    2'd2, B_G,     2'd0, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd13: u = uop_mk(A_W,    2'd0, B_G,     2'd2, ACC_SET,    1'b0, WB_T,    2'd0);
      6'd14: u = uop_mk(A_G,    2'd1, B_PF,    2'd0, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd15: u = uop_mk(A_W,    2'd0, B_G,     2'd1, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd16: u = uop_mk(A_W,    2'd1, B_G,     2'd0, ACC_SET,    1'b0, WB_T,    2'd1);
      6'd17: u = uop_mk(A_G,    2'd2, B_PF,    2'd0, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      // normalization factor: 3 << 2f - |t|^2
      6'd18: u = uop_mk(A_TH,   2'd0, B_PF,    2'd0, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd19: u = uop_mk(A_T,    2'd0, B_T,     2'd0, ACC_SET,    1'b0, WB_T,    2'd2);
      6'd20: u = uop_mk(A_T,    2'd1, B_T,     2'd1, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd21: u = uop_mk(A_T,    2'd2, B_T,     2'd2, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd22: u = uop_mk(A_ZERO, 2'd0, B_ZERO,  2'd0, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd23: u = uop_mk(A_ZERO, 2'd0, B_ZERO,  2'd0, ACC_HOLD,   1'b0, WB_H,    2'd0);
      // new gravity: t * h
      6'd24: u = uop_mk(A_T,    2'd0, B_H,     2'd0, ACC_HOLD,   1'b0, WB_NONE, 2'd0);
      6'd25: u = uop_mk(A_T,    2'd1, B_H,     2'd0, ACC_SET,    1'b0, WB_NONE, 2'd0);
      6'd26: u = uop_mk(A_T,    2'd2, B_H,     2'd0, ACC_SET,    1'b0, WB_G,    2'd0);
      6'd27: u = uop_mk(A_ZERO, 2'd0, B_ZERO,  2'd0, ACC_SET,    1'b0, WB_G,    2'd1);
      // accel x gravity, z component first
      6'd28: u = uop_mk(A_A,    2'd0, B_G,     2'd1, ACC_HOLD,   1'b0, WB_G,    2'd2);
      6'd29: u = uop_mk(A_A,    2'd1, B_G,     2'd0, ACC_SET,    1'b0, WB_NONE, 2'd0);
      6'd30: u = uop_mk(A_A,    2'd1, B_G,     2'd2, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd31: u = uop_mk(A_A,    2'd2, B_G,     2'd1, ACC_SET,    1'b0, WB_D,    2'd2);
      6'd32: u = uop_mk(A_A,    2'd2, B_G,     2'd0, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd33: u = uop_mk(A_A,    2'd0, B_G,     2'd2, ACC_SET,    1'b0, WB_D,    2'd0);
      // correction: d * kp in two halves
      6'd34: u = uop_mk(A_DH,   2'd2, B_K,     2'd0, ACC_SUB,    1'b0, WB_NONE, 2'd0);
      6'd35: u = uop_mk(A_DL,   2'd2, B_K,     2'd0, ACC_SET,    1'b1, WB_D,    2'd1);
      6'd36: u = uop_mk(A_DH,   2'd0, B_K,     2'd0, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd37: u = uop_mk(A_DL,   2'd0, B_K,     2'd0, ACC_SET,    1'b1, WB_CORR, 2'd2);
      6'd38: u = uop_mk(A_DH,   2'd1, B_K,     2'd0, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd39: u = uop_mk(A_DL,   2'd1, B_K,     2'd0, ACC_SET,    1'b1, WB_CORR, 2'd0);
      6'd40: u = uop_mk(A_ZERO, 2'd0, B_ZERO,  2'd0, ACC_ADD,    1'b0, WB_NONE, 2'd0);
      6'd41: u = uop_mk(A_ZERO, 2'd0, B_ZERO,  2'd0, ACC_HOLD,   1'b0, WB_CORR, 2'd1);
      default: u = UOP_IDLE;
    endcase
    return u;
  endfunction

endpackage

### src/gvcf_mac.sv
// gvcf_mac: the shared 33x33 signed multiplier with a product register and
// the wide accumulator behind it. Depends on gvcf_pkg.

module gvcf_mac
  import gvcf_pkg::*;
(
  input  logic                    clk,
  input  logic signed [OPW-1:0]   op_a,
  input  logic signed [OPW-1:0]   op_b,
  input  accop_t                  acc_op,
  input  logic                    acc_shl,
  output logic signed [ACC_W-1:0] acc_r
);

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  p_ext;
  logic signed [ACC_W-1:0]  p_sel;
  logic signed [ACC_W-1:0]  acc_nxt;

  assign prod_nxt = op_a * op_b;
  assign p_ext    = ACC_W'(prod_r);
  // high half of a split operand lands DL_W bits up
  assign p_sel    = acc_shl ? (p_ext <<< DL_W) : p_ext;

  always_comb begin
    unique case (acc_op)
      ACC_SET:    acc_nxt = p_sel;
      ACC_SETNEG: acc_nxt = -p_sel;
      ACC_ADD:    acc_nxt = acc_r + p_sel;
      ACC_SUB:    acc_nxt = acc_r - p_sel;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

### src/gvcf_rndsat.sv
// gvcf_rndsat: round-half-up shift and 32-bit saturation of the accumulator,
// shift chosen by the writeback target. Depends on gvcf_pkg.

module gvcf_rndsat
  import gvcf_pkg::*;
#(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
)
(
  input  logic signed [ACC_W-1:0] acc,
  input  wb_t                     kind,
  output logic signed [31:0]      val
);

  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  logic [5:0]              sh;
  logic                    minus;
  logic signed [ACC_W-1:0] bias;
  logic signed [ACC_W-1:0] v;
  logic signed [ACC_W-1:0] r;

  always_comb begin
    unique case (kind)
      WB_RATE: sh = 6'd16;
      WB_W:    sh = 6'(40 - VEC_FRAC_BITS);
      WB_T:    sh = 6'(VEC_FRAC_BITS);
      WB_H:    sh = 6'(VEC_FRAC_BITS);
      WB_G:    sh = 6'(VEC_FRAC_BITS + 1);
      WB_CORR: sh = 6'd32;
      default: sh = 6'd1;
    endcase
  end

  // h is 3 - m with m rounded half up, so its bias is one less
  assign minus = (kind == WB_H);
  assign bias  = $signed((ACC_W'(1) << (sh - 6'd1)) - ACC_W'(minus));
  assign v     = acc + bias;
  assign r     = v >>> sh;

  always_comb begin
    if (r > SMAX) begin
      val = 32'sh7FFF_FFFF;
    end else if (r < SMIN) begin
      val = 32'sh8000_0000;
    end else begin
      val = r[31:0];
    end
  end

endmodule

### src/gvcf_seq.sv
// gvcf_seq: step counter that walks the microprogram once per accepted
// sample and holds the last step until the output register is free.
// Depends on gvcf_pkg.

module gvcf_seq
  import gvcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic out_free,
  output ctl_t ctl
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              running;

  assign running  = (state_r == S_RUN);
  assign ctl.busy = running;
  assign ctl.done = running && (step_r == LAST_STEP) && out_free;
  assign ctl.uop  = running ? gvcf_uop(step_r) : UOP_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            step_r  <= '0;
          end
        end
        S_RUN: begin
          if (step_r == LAST_STEP) begin
            if (out_free) state_r <= S_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> running && (step_r == '0))
    else $error("sample request did not start the microprogram at step zero");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    running |-> (step_r <= LAST_STEP))
    else $error("step counter ran past the last step");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> !running)
    else $error("sequencer did not return to idle after finishing");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    running && !ctl.done |=> !start || $past(ctl.done))
    else $error("request accepted while a sample was in progress");

endmodule

### src/gravity_vector_complementary_filter.sv
// Gravity vector complementary filter: one shared 33x33 multiplier-accumulator
// driven by a 43-step microprogram.
// One sample at a time: in_stall is high until the result is written. The pace
// is set by the 37 products of the single shared multiplier, the waits on its
// two-stage multiply/accumulate path and a hold while the output is stalled.
// Reset (synchronous, rst_n low): gravity (0, 0, -1), correction zero, registers
// to their defaults, no result pending.

module gravity_vector_complementary_filter
  import gvcf_pkg::*;
#(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [OPW-1:0] PF_C  = OPW'(64'd1 << VEC_FRAC_BITS);
  localparam logic signed [OPW-1:0] P40_C = OPW'(64'd1 << (40 - VEC_FRAC_BITS));
  localparam logic signed [OPW-1:0] TH_C  = OPW'(64'd3 << VEC_FRAC_BITS);
  localparam logic signed [31:0]    GZ_RESET = 32'(-(64'sd1 <<< VEC_FRAC_BITS));

  ctl_t ctl;
  uop_t uop;
  logic start;
  logic out_free;

  logic [15:0] kp_r;
  logic [23:0] gs_r;
  logic [30:0] gs100_r;
  logic [30:0] gs_ext;
  logic [30:0] gs100_nxt;

  logic signed [15:0]    a_r    [3];
  logic signed [15:0]    c_r    [3];
  logic signed [31:0]    rate_r [3];
  logic signed [31:0]    w_r    [3];
  logic signed [31:0]    t_r    [3];
  logic signed [31:0]    g_r    [3];
  logic signed [31:0]    corr_r [3];
  logic        [D_W-1:0] d_r    [3];
  logic signed [31:0]    h_r;

  logic signed [OPW-1:0]   op_a;
  logic signed [OPW-1:0]   op_b;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]      rs_val;

  out_t out_data_r;
  logic out_valid_r;

  assign uop       = ctl.uop;
  assign start     = in_valid && !in_stall;
  assign in_stall  = ctl.busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // gyro_scale * 100 kept alongside for the rate products
  assign gs_ext    = 31'(cfg_data);
  assign gs100_nxt = (gs_ext << 6) + (gs_ext << 5) + (gs_ext << 2);

  gvcf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .ctl      (ctl)
  );

  always_comb begin
    unique case (uop.a_sel)
      A_C:     op_a = OPW'(c_r[uop.a_idx]);
      A_CORR:  op_a = OPW'(corr_r[uop.a_idx]);
      A_W:     op_a = OPW'(w_r[uop.a_idx]);
      A_G:     op_a = OPW'(g_r[uop.a_idx]);
      A_T:     op_a = OPW'(t_r[uop.a_idx]);
      A_A:     op_a = OPW'(a_r[uop.a_idx]);
      A_DH:    op_a = OPW'($signed(d_r[uop.a_idx][D_W-1:DL_W]));
      A_DL:    op_a = OPW'(d_r[uop.a_idx][DL_W-1:0]);
      A_TH:    op_a = TH_C;
      default: op_a = '0;
    endcase
  end

  always_comb begin
    unique case (uop.b_sel)
      B_GS100: op_b = OPW'(gs100_r);
      B_GS:    op_b = OPW'(gs_r);
      B_P40:   op_b = P40_C;
      B_PF:    op_b = PF_C;
      B_G:     op_b = OPW'(g_r[uop.b_idx]);
      B_T:     op_b = OPW'(t_r[uop.b_idx]);
      B_H:     op_b = OPW'(h_r);
      B_K:     op_b = OPW'(kp_r);
      default: op_b = '0;
    endcase
  end

  gvcf_mac u_mac (
    .clk     (clk),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc_op  (uop.acc_op),
    .acc_shl (uop.acc_shl),
    .acc_r   (acc_r)
  );

  gvcf_rndsat #(
    .VEC_FRAC_BITS (VEC_FRAC_BITS)
  ) u_rndsat (
    .acc  (acc_r),
    .kind (uop.wb),
    .val  (rs_val)
  );

  // kept state, configuration and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= KP_RESET;
      gs_r        <= GS_RESET;
      gs100_r     <= GS100_RESET;
      g_r[0]      <= '0;
      g_r[1]      <= '0;
      g_r[2]      <= GZ_RESET;
      corr_r[0]   <= '0;
      corr_r[1]   <= '0;
      corr_r[2]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KP_GAIN:    kp_r <= cfg_data[15:0];
          CFG_GYRO_SCALE: begin
            gs_r    <= cfg_data[23:0];
            gs100_r <= gs100_nxt;
          end
          default: ;
        endcase
      end
      if (uop.wb == WB_G) g_r[uop.wb_idx] <= rs_val;
      if (uop.wb == WB_CORR) corr_r[uop.wb_idx] <= rs_val;
      if (ctl.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample latch, intermediates and output payload
  always_ff @(posedge clk) begin
    if (start) begin
      a_r[0] <= in_data.accel_x;
      a_r[1] <= in_data.accel_y;
      a_r[2] <= in_data.accel_z;
      c_r[0] <= in_data.gyro_x;
      c_r[1] <= in_data.gyro_y;
      c_r[2] <= in_data.gyro_z;
    end
    unique case (uop.wb)
      WB_RATE: rate_r[uop.wb_idx] <= rs_val;
      WB_W:    w_r[uop.wb_idx]    <= rs_val;
      WB_T:    t_r[uop.wb_idx]    <= rs_val;
      WB_H:    h_r                <= rs_val;
      WB_D:    d_r[uop.wb_idx]    <= acc_r[D_W-1:0];
      default: ;
    endcase
    if (ctl.done) begin
      out_data_r.grav_x <= g_r[0];
      out_data_r.grav_y <= g_r[1];
      out_data_r.grav_z <= g_r[2];
      out_data_r.rate_x <= rate_r[0];
      out_data_r.rate_y <= rate_r[1];
      out_data_r.rate_z <= rate_r[2];
    end
  end

endmodule
